// File: hdl/gla_pkg.sv
package gla_pkg;

  // Default sample width and fixed-point formats of the power unit.
  localparam int PIXEL_BITS_DEF = 16;
  localparam int LOG_FRAC       = 28;
  localparam int MANT_FRAC      = 30;
  localparam int GAMMA_FRAC     = 12;
  localparam int GAMMA_W        = 16;
  localparam logic [GAMMA_W-1:0] GAMMA_ONE = 16'd4096;

  // Register file layout.
  localparam int CFG_DW    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BLACK_IN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_IN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLACK_OUT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_OUT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAMMA     = 3'd4;

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.30 value of 2^(2^-k), built by repeated square roots of 2.0.
  function automatic logic [MANT_FRAC:0] root_const(input int k);
    logic [63:0] c;
    c = 64'd1 << (MANT_FRAC + 1);
    for (int i = 1; i <= LOG_FRAC; i++) begin
      if (i <= k) begin
        c = isqrt64(c << MANT_FRAC);
      end
    end
    return c[MANT_FRAC:0];
  endfunction

endpackage

// File: hdl/gla_norm.sv
module gla_norm #(
  parameter int P = gla_pkg::PIXEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [P-1:0] pix,
  input  logic [P-1:0] lo_in,
  input  logic [P-1:0] hi_in,
  output logic         vld_o,
  output logic [P+1:0] t_o
);

  localparam int QW = P + 2;

  logic [P-1:0]  a_w;
  logic [P-1:0]  den_w;
  logic          zero_w;
  logic          sat_w;

  logic [QW:0]   vld_r;
  logic [QW:0]   zero_r;
  logic [QW:0]   sat_r;
  logic [P-1:0]  rem_r   [QW+1];
  logic [P-1:0]  rem_nxt [QW+1];
  logic [QW-1:0] q_r     [QW+1];
  logic [QW-1:0] q_nxt   [QW+1];
  logic [1:0]    alo_r   [QW+1];

  // Entry: offset, span and the saturating cases.
  always_comb begin
    a_w    = pix - lo_in;
    den_w  = hi_in - lo_in;
    zero_w = (pix <= lo_in);
    sat_w  = (hi_in <= lo_in) || ({2'b00, a_w[P-1:2]} >= den_w);
  end

  // One restoring quotient bit per stage, most significant first.
  always_comb begin
    logic [P:0] sh;
    logic       nb;
    logic       qb;
    rem_nxt[0] = {2'b00, a_w[P-1:2]};
    q_nxt[0]   = '0;
    for (int k = 1; k <= QW; k++) begin
      if (k == 1) begin
        nb = alo_r[k-1][1];
      end else if (k == 2) begin
        nb = alo_r[k-1][0];
      end else begin
        nb = 1'b0;
      end
      sh = {rem_r[k-1], nb};
      if (sh >= {1'b0, den_w}) begin
        rem_nxt[k] = P'(sh - {1'b0, den_w});
        qb         = 1'b1;
      end else begin
        rem_nxt[k] = sh[P-1:0];
        qb         = 1'b0;
      end
      q_nxt[k] = {q_r[k-1][QW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      q_r[0]    <= q_nxt[0];
      alo_r[0]  <= a_w[1:0];
      zero_r[0] <= zero_w;
      sat_r[0]  <= sat_w;
      for (int k = 1; k <= QW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        alo_r[k]  <= alo_r[k-1];
        zero_r[k] <= zero_r[k-1];
        sat_r[k]  <= sat_r[k-1];
      end
    end
  end

  // Samples at or below the black point read as zero; overflow saturates.
  assign vld_o = vld_r[QW];
  assign t_o   = zero_r[QW] ? '0 : (sat_r[QW] ? '1 : q_r[QW]);

endmodule

// File: hdl/gla_pow.sv
module gla_pow #(
  parameter int P = gla_pkg::PIXEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [P+1:0]                t_i,
  input  logic [gla_pkg::GAMMA_W-1:0] gamma,
  output logic                        vld_o,
  output logic [2*P:0]                u_o
);

  localparam int TW  = P + 2;
  localparam int PW  = $clog2(P + 2);
  localparam int LF  = gla_pkg::LOG_FRAC;
  localparam int MF  = gla_pkg::MANT_FRAC;
  localparam int MW  = MF + 1;
  localparam int GF  = gla_pkg::GAMMA_FRAC;
  localparam int GW  = gla_pkg::GAMMA_W;
  localparam int IW  = PW + 1;
  localparam int LGW = IW + LF;
  localparam int PRW = LGW + GW + 1;
  localparam int YW  = PRW - GF;
  localparam int NW  = YW - LF;
  localparam int EW  = $clog2(2 * P + 1);
  localparam int UW  = 2 * P + 1;
  localparam int NS  = 2 * LF + 4;

  typedef struct packed {
    logic tzero;
    logic sat;
    logic tiny;
  } pflag_t;

  logic [NS-1:0]  vld_r;

  // Entry stage signals.
  logic [PW-1:0]    p_w;
  logic [TW+MF-1:0] xs_w;

  // Log stages: index 0 is the entry register.
  logic [MW-1:0] x_r     [LF+1];
  logic [MW-1:0] x_nxt   [LF+1];
  logic [LF-1:0] frac_r  [LF+1];
  logic [LF-1:0] frac_nxt[LF+1];
  logic [PW-1:0] p_r     [LF+1];
  logic [TW-1:0] tl_r    [LF+1];
  pflag_t        fl_r    [LF+1];

  // Exponent product stage.
  logic signed [IW-1:0]  ip_w;
  logic signed [LGW-1:0] lg_w;
  logic signed [PRW-1:0] prod_w;
  logic [YW-1:0]         y_r;
  logic [TW-1:0]         ty_r;
  pflag_t                fy_r;

  // Split stage signals.
  logic signed [NW-1:0] n_w;
  logic signed [NW:0]   ef_w;

  // Root stages: index 0 is the split register.
  logic [MW-1:0] m_r   [LF+1];
  logic [MW-1:0] m_nxt [LF+1];
  logic [MW-1:0] cst   [LF+1];
  logic [LF-1:0] f_r   [LF+1];
  logic [EW-1:0] e_r   [LF+1];
  logic [TW-1:0] tm_r  [LF+1];
  pflag_t        fm_r  [LF+1];

  // Output stage.
  logic [MW+2*P-1:0] wide_w;
  logic [UW-1:0]     u_nxt;
  logic [UW-1:0]     u_r;

  // Leading one and Q1.30 mantissa of the base.
  always_comb begin
    p_w = '0;
    for (int i = 0; i < TW; i++) begin
      if (t_i[i]) begin
        p_w = PW'(i);
      end
    end
    xs_w = {t_i, {MF{1'b0}}} >> p_w;
  end

  // One squaring per stage gives one fraction bit of log2.
  always_comb begin
    logic [2*MW-1:0] sq;
    logic [MW:0]     s;
    x_nxt[0]    = xs_w[MW-1:0];
    frac_nxt[0] = '0;
    for (int k = 1; k <= LF; k++) begin
      sq = (2*MW)'(x_r[k-1]) * (2*MW)'(x_r[k-1]);
      s  = sq[2*MW-1:MF];
      if (s[MW]) begin
        x_nxt[k]    = s[MW:1];
        frac_nxt[k] = {frac_r[k-1][LF-2:0], 1'b1};
      end else begin
        x_nxt[k]    = s[MW-1:0];
        frac_nxt[k] = {frac_r[k-1][LF-2:0], 1'b0};
      end
    end
  end

  // log2 times the exponent, floored to 28 fraction bits.
  always_comb begin
    ip_w   = signed'(IW'(p_r[LF])) - signed'(IW'(P));
    lg_w   = signed'({ip_w, frac_r[LF]});
    prod_w = PRW'(lg_w) * signed'(PRW'({1'b0, gamma}));
  end

  // Integer and fraction parts of the exponent; range checks.
  always_comb begin
    n_w  = signed'(y_r[YW-1:LF]);
    ef_w = signed'({n_w[NW-1], n_w}) + signed'((NW+1)'(P));
  end

  // Fraction bits select the root constants to multiply in.
  for (genvar r = 0; r <= LF; r++) begin : g_root
    localparam logic [MW-1:0] C = gla_pkg::root_const(r);
    assign cst[r] = C;
  end

  assign m_nxt[0] = MW'(1) << MF;
  for (genvar r = 1; r <= LF; r++) begin : g_mul
    logic [2*MW-1:0] mp;
    assign mp       = (2*MW)'(m_r[r-1]) * (2*MW)'(cst[r]);
    assign m_nxt[r] = f_r[r-1][LF-r] ? mp[MF+MW-1:MF] : m_r[r-1];
  end

  // Scale the mantissa and resolve the special cases.
  always_comb begin
    wide_w = (MW+2*P)'(m_r[LF]) << e_r[LF];
    if (gamma == gla_pkg::GAMMA_ONE) begin
      u_nxt = UW'(tm_r[LF]);
    end else if (gamma == '0) begin
      u_nxt = UW'(1) << P;
    end else if (fm_r[LF].tzero) begin
      u_nxt = '0;
    end else if (fm_r[LF].sat) begin
      u_nxt = '1;
    end else if (fm_r[LF].tiny) begin
      u_nxt = '0;
    end else begin
      u_nxt = wide_w[MF +: UW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_nxt[0];
      frac_r[0] <= frac_nxt[0];
      p_r[0]    <= p_w;
      tl_r[0]   <= t_i;
      fl_r[0]   <= '{tzero: (t_i == '0), sat: 1'b0, tiny: 1'b0};
      for (int k = 1; k <= LF; k++) begin
        x_r[k]    <= x_nxt[k];
        frac_r[k] <= frac_nxt[k];
        p_r[k]    <= p_r[k-1];
        tl_r[k]   <= tl_r[k-1];
        fl_r[k]   <= fl_r[k-1];
      end
      y_r  <= prod_w[PRW-1:GF];
      ty_r <= tl_r[LF];
      fy_r <= fl_r[LF];
      m_r[0]  <= m_nxt[0];
      f_r[0]  <= y_r[LF-1:0];
      e_r[0]  <= ef_w[EW-1:0];
      tm_r[0] <= ty_r;
      fm_r[0] <= '{tzero: fy_r.tzero,
                   sat:   (n_w > signed'(NW'(P))),
                   tiny:  ef_w[NW]};
      for (int r = 1; r <= LF; r++) begin
        m_r[r]  <= m_nxt[r];
        f_r[r]  <= f_r[r-1];
        e_r[r]  <= e_r[r-1];
        tm_r[r] <= tm_r[r-1];
        fm_r[r] <= fm_r[r-1];
      end
      u_r <= u_nxt;
    end
  end

  assign vld_o = vld_r[NS-1];
  assign u_o   = u_r;

endmodule

// File: hdl/gla_map.sv
module gla_map #(
  parameter int P = gla_pkg::PIXEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [2*P:0] u_i,
  input  logic [P-1:0] lo_out,
  input  logic [P-1:0] hi_out,
  output logic         vld_o,
  output logic [P-1:0] pix_o
);

  localparam int UW = 2 * P + 1;

  logic [1:0]    vld_r;
  logic          neg_w;
  logic [P-1:0]  ad_w;
  logic [UW+P-1:0] prod_w;
  logic [UW-1:0] mag_r;
  logic [UW:0]   v_w;
  logic [P-1:0]  pix_nxt;
  logic [P-1:0]  pix_r;

  // Scale by the output span, truncating the magnitude.
  always_comb begin
    neg_w  = (hi_out < lo_out);
    ad_w   = neg_w ? (lo_out - hi_out) : (hi_out - lo_out);
    prod_w = (UW+P)'(u_i) * (UW+P)'(ad_w);
  end

  // Offset from the output black point and clamp to the sample range.
  always_comb begin
    if (neg_w) begin
      v_w     = (UW+1)'(lo_out) - (UW+1)'(mag_r);
      pix_nxt = v_w[UW] ? '0 : v_w[P-1:0];
    end else begin
      v_w     = (UW+1)'(lo_out) + (UW+1)'(mag_r);
      pix_nxt = (v_w[UW:P] != '0) ? '1 : v_w[P-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= prod_w[UW+P-1:P];
      pix_r <= pix_nxt;
    end
  end

  assign vld_o = vld_r[1];
  assign pix_o = pix_r;

endmodule

// File: hdl/gamma_levels_adjust.sv
// Levels and gamma adjustment of a stream of samples.
// Input: in_valid/in_ready carry one Q0.P sample request, in_pixel_in.
// Output: out_valid/out_ready carry one adjusted sample, out_pixel_out.
// The sample is normalized against the input black and white points,
// raised to the programmed Q4.12 exponent, mapped onto the output range
// and clamped to full scale.
// Throughput is one sample per clock while the output is not stalled. The
// pipeline holds P + 3 stages of the bit-per-stage normalizing divider, 60
// stages of the log/exp power unit (28 squaring stages and 28 root-multiply
// stages) and 2 mapping stages.
// All stages advance together; when out_valid is high and out_ready low the
// whole pipeline holds and in_ready drops, so nothing is lost or repeated.
// Registers sit on an APB port at byte addresses 4*i and must be written
// only while no sample is in flight. A synchronous reset empties the
// pipeline and loads the identity setting: black points 0, white points
// full scale, exponent 1.0.
module gamma_levels_adjust #(
  parameter int PIXEL_BITS = gla_pkg::PIXEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [PIXEL_BITS-1:0]       in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [PIXEL_BITS-1:0]       out_pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gla_pkg::ADDR_W-1:0]  paddr,
  input  logic [gla_pkg::CFG_DW-1:0]  pwdata,
  output logic [gla_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int P  = PIXEL_BITS;
  localparam int GW = gla_pkg::GAMMA_W;
  localparam int DW = gla_pkg::CFG_DW;

  logic [P-1:0]  lo_in_r;
  logic [P-1:0]  hi_in_r;
  logic [P-1:0]  lo_out_r;
  logic [P-1:0]  hi_out_r;
  logic [GW-1:0] gamma_r;
  logic          wr_en;
  logic [gla_pkg::REG_IDX_W-1:0] reg_idx;

  logic          en;
  logic          norm_vld;
  logic [P+1:0]  norm_t;
  logic          pow_vld;
  logic [2*P:0]  pow_u;

  // Register file write and read.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[gla_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_in_r  <= '0;
      hi_in_r  <= '1;
      lo_out_r <= '0;
      hi_out_r <= '1;
      gamma_r  <= gla_pkg::GAMMA_ONE;
    end else if (wr_en) begin
      case (reg_idx)
        gla_pkg::REG_BLACK_IN:  lo_in_r  <= pwdata[P-1:0];
        gla_pkg::REG_WHITE_IN:  hi_in_r  <= pwdata[P-1:0];
        gla_pkg::REG_BLACK_OUT: lo_out_r <= pwdata[P-1:0];
        gla_pkg::REG_WHITE_OUT: hi_out_r <= pwdata[P-1:0];
        gla_pkg::REG_GAMMA:     gamma_r  <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gla_pkg::REG_BLACK_IN:  prdata = DW'(lo_in_r);
      gla_pkg::REG_WHITE_IN:  prdata = DW'(hi_in_r);
      gla_pkg::REG_BLACK_OUT: prdata = DW'(lo_out_r);
      gla_pkg::REG_WHITE_OUT: prdata = DW'(hi_out_r);
      gla_pkg::REG_GAMMA:     prdata = DW'(gamma_r);
      default:                prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is free or drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  gla_norm #(.P(P)) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .pix   (in_pixel_in),
    .lo_in (lo_in_r),
    .hi_in (hi_in_r),
    .vld_o (norm_vld),
    .t_o   (norm_t)
  );

  gla_pow #(.P(P)) u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (norm_vld),
    .t_i   (norm_t),
    .gamma (gamma_r),
    .vld_o (pow_vld),
    .u_o   (pow_u)
  );

  gla_map #(.P(P)) u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (pow_vld),
    .u_i    (pow_u),
    .lo_out (lo_out_r),
    .hi_out (hi_out_r),
    .vld_o  (out_valid),
    .pix_o  (out_pixel_out)
  );

`ifndef NO_ASSERTIONS
  // A held result must stop new requests from entering.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the output is stalled");

  // With a rising output range, results never fall below the black point.
  a_rising_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (hi_out_r >= lo_out_r)) |-> (out_pixel_out >= lo_out_r))
    else $error("result below output black point");

  // With an inverted output range, results never rise above the black point.
  a_inverted_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (hi_out_r < lo_out_r)) |-> (out_pixel_out <= lo_out_r))
    else $error("result above output black point in inverted range");
`endif

endmodule

// File: dv/gamma_levels_adjust_tb.sv
`timescale 1ns / 100ps

module gamma_levels_adjust_tb;

  localparam int PB = 16;
  localparam int AW = gla_pkg::ADDR_W;
  localparam logic [gla_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam longint unsigned PIX_MAX = (64'd1 << PB) - 1;
  localparam longint unsigned NORM_MAX = (64'd4 << PB) - 1;
  localparam longint unsigned POW_MAX = (64'd2 << (2 * PB)) - 1;
  localparam longint unsigned MANT_UNIT = 64'd1 << gla_pkg::MANT_FRAC;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PB-1:0] in_pixel_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PB-1:0] out_pixel_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [gla_pkg::CFG_DW-1:0] pwdata = '0;
  logic [gla_pkg::CFG_DW-1:0] prdata;
  logic pready;

  // Shadow copy of the level and exponent registers.
  logic [PB-1:0] sh_lo_in;
  logic [PB-1:0] sh_hi_in;
  logic [PB-1:0] sh_lo_out;
  logic [PB-1:0] sh_hi_out;
  logic [gla_pkg::GAMMA_W-1:0] lvl_gamma;

  longint unsigned root_of_two [0:gla_pkg::LOG_FRAC];
  logic [PB-1:0] pending_pixels [$];
  logic no_idle = 1'b0;
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int settings = 0;

  gamma_levels_adjust #(.PIXEL_BITS(PB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_out(out_pixel_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Bitwise integer square root, used to build the root constants.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // Raises a Q2.P normalized value to a Q4.12 exponent through log2 and exp2.
  function automatic longint unsigned raise_power(input longint unsigned t,
                                                  input logic [gla_pkg::GAMMA_W-1:0] g);
    int lead;
    int sh;
    longint unsigned x;
    longint unsigned frac;
    longint unsigned m;
    longint unsigned f;
    longint lg;
    longint y;
    longint n;
    if (g == 0) return 64'd1 << PB;
    if (t == 0) return 0;
    lead = 0;
    while (lead < 62 && (t >> (lead + 1)) != 0) lead++;
    x = t << (gla_pkg::MANT_FRAC - lead);
    frac = 0;
    for (int i = 0; i < gla_pkg::LOG_FRAC; i++) begin
      x = (x * x) >> gla_pkg::MANT_FRAC;
      frac = frac << 1;
      if (x >= (MANT_UNIT << 1)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    lg = longint'(lead - PB) * (longint'(1) <<< gla_pkg::LOG_FRAC) + longint'(frac);
    y = (lg * longint'({48'd0, g})) >>> gla_pkg::GAMMA_FRAC;
    n = y >>> gla_pkg::LOG_FRAC;
    f = longint'(y - (n <<< gla_pkg::LOG_FRAC));
    if (n > PB) return POW_MAX;
    m = MANT_UNIT;
    for (int i = 1; i <= gla_pkg::LOG_FRAC; i++) begin
      if ((f >> (gla_pkg::LOG_FRAC - i)) & 1)
        m = (m * root_of_two[i]) >> gla_pkg::MANT_FRAC;
    end
    sh = int'(n) + PB - gla_pkg::MANT_FRAC;
    if (sh >= 0) m = m << sh;
    else if (-sh >= 63) m = 0;
    else m = m >> (-sh);
    return (m > POW_MAX) ? POW_MAX : m;
  endfunction

  // Expected adjusted sample for the current register settings.
  function automatic logic [PB-1:0] adjusted_pixel(input logic [PB-1:0] pix);
    longint unsigned t;
    longint unsigned u;
    longint unsigned span;
    longint unsigned mag;
    longint d;
    longint v;
    if (pix <= sh_lo_in) t = 0;
    else if (sh_hi_in <= sh_lo_in) t = NORM_MAX;
    else begin
      t = (longint'(pix - sh_lo_in) << PB) / longint'(sh_hi_in - sh_lo_in);
      if (t > NORM_MAX) t = NORM_MAX;
    end
    u = (lvl_gamma == gla_pkg::GAMMA_ONE) ? t : raise_power(t, lvl_gamma);
    d = longint'(sh_hi_out) - longint'(sh_lo_out);
    span = (d < 0) ? -d : d;
    mag = (u >> PB) * span + (((u & PIX_MAX) * span) >> PB);
    v = (d < 0) ? longint'(sh_lo_out) - longint'(mag)
                : longint'(sh_lo_out) + longint'(mag);
    if (v < 0) v = 0;
    if (v > longint'(PIX_MAX)) v = PIX_MAX;
    return v[PB-1:0];
  endfunction

  // Result side stalls at random unless idling is switched off.
  always @(negedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);
  end

  // Compare every accepted result with the oldest expected sample.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_pixel_out);
        errors++;
      end else begin
        if (out_pixel_out !== pending_pixels[0]) begin
          $display("%0t: pixel_out mismatch, expected %h, actual %h",
                   $time, pending_pixels[0], out_pixel_out);
          errors++;
        end
        void'(pending_pixels.pop_front());
        checked++;
      end
    end
  end

  // Sends one request; entered and left at a falling edge, valid left high.
  task automatic push_pixel(input logic [PB-1:0] pix);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pixel_in = pix;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(adjusted_pixel(pix));
    sent++;
    @(negedge clk);
  endtask

  // Waits until every result is back and the pipeline has emptied.
  task automatic drain;
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(input logic [gla_pkg::REG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = AW'(idx) << 2;
    pwdata = {16'($urandom), val};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      gla_pkg::REG_BLACK_IN: sh_lo_in = val;
      gla_pkg::REG_WHITE_IN: sh_hi_in = val;
      gla_pkg::REG_BLACK_OUT: sh_lo_out = val;
      gla_pkg::REG_WHITE_OUT: sh_hi_out = val;
      gla_pkg::REG_GAMMA: lvl_gamma = val;
      default: ;
    endcase
  endtask

  task automatic set_levels(input logic [15:0] bi, input logic [15:0] wi,
                            input logic [15:0] bo, input logic [15:0] wo,
                            input logic [15:0] g);
    drain();
    write_reg(gla_pkg::REG_BLACK_IN, bi);
    write_reg(gla_pkg::REG_WHITE_IN, wi);
    write_reg(gla_pkg::REG_BLACK_OUT, bo);
    write_reg(gla_pkg::REG_WHITE_OUT, wo);
    write_reg(gla_pkg::REG_GAMMA, g);
    settings++;
  endtask

  // Reset settings: identity mapping with the extremes and mid-range samples.
  task automatic test_identity;
    push_pixel(16'h0000);
    push_pixel(16'hFFFF);
    push_pixel(16'h8000);
    push_pixel(16'h5555);
    push_pixel(16'hAAAA);
  endtask

  // Levels with square gamma, samples around both input points.
  task automatic test_levels;
    set_levels(16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'd8192);
    push_pixel(16'h0FFF);
    push_pixel(16'h1000);
    push_pixel(16'h1001);
    push_pixel(16'hF000);
    push_pixel(16'hFFFF);
    // A write to an unused register index must change nothing.
    drain();
    write_reg(REG_UNUSED, 16'h1234);
    push_pixel(16'h7000);
  endtask

  // Zero span, inverted output, zero and extreme exponents.
  task automatic test_corners;
    set_levels(16'h4000, 16'h4000, 16'hFFFF, 16'h0000, gla_pkg::GAMMA_ONE);
    push_pixel(16'h4000);
    push_pixel(16'h4001);
    set_levels(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd0);
    push_pixel(16'h0000);
    push_pixel(16'h9000);
    set_levels(16'h0000, 16'h0010, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_pixel(16'h0001);
    push_pixel(16'hFFFF);
    set_levels(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_pixel(16'h0001);
    push_pixel(16'h8000);
    set_levels(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'd1);
    push_pixel(16'hFFFF);
    push_pixel(16'h0001);
  endtask

  function automatic logic [15:0] pick_level;
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random settings per phase, each followed by a burst of random samples.
  task automatic test_random;
    logic [15:0] bi;
    logic [15:0] wi;
    logic [15:0] g;
    logic [PB-1:0] pix;
    for (int ph = 0; ph < 9; ph++) begin
      bi = pick_level();
      wi = pick_level();
      // Mostly a proper input range so the power path is exercised.
      if ($urandom_range(3) != 0 && wi <= bi) {bi, wi} = {wi, bi};
      case ($urandom_range(5))
        0: g = gla_pkg::GAMMA_ONE;
        1: g = 16'($urandom_range(1, 8191));
        2: g = 16'($urandom_range(0, 600));
        3: g = 16'hFFFF;
        default: g = 16'($urandom);
      endcase
      set_levels(bi, wi, pick_level(), pick_level(), g);
      no_idle = (ph == 4);
      for (int i = 0; i < 55; i++) begin
        case ($urandom_range(7))
          0: pix = bi + 16'($urandom_range(0, 3)) - 16'd1;
          1: pix = wi + 16'($urandom_range(0, 3)) - 16'd1;
          default: pix = 16'($urandom);
        endcase
        push_pixel(pix);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    sh_lo_in = '0;
    sh_hi_in = '1;
    sh_lo_out = '0;
    sh_hi_out = '1;
    lvl_gamma = gla_pkg::GAMMA_ONE;
    root_of_two[0] = 64'd2 << gla_pkg::MANT_FRAC;
    for (int k = 1; k <= gla_pkg::LOG_FRAC; k++)
      root_of_two[k] = int_sqrt(root_of_two[k-1] << gla_pkg::MANT_FRAC);
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_identity();
    test_levels();
    test_corners();
    test_random();
    drain();
    $display("Sent %0d samples over %0d register settings, %0d results checked.",
             sent, settings, checked);
    $display("Covered zero span, inverted output, zero, unity and extreme exponents.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
